// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the descriptor search RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/tds_pkg.sv =====
// Package for the TLV descriptor search unit: sizes, codes, known types, payload structs.
// No dependencies; imported by tds_walker and tlv_descriptor_search_unit.
package tds_pkg;

  // Memory geometry
  localparam int MEM_BYTES    = 512;
  localparam int HEADER_BYTES = 4;
  localparam int AW           = $clog2(MEM_BYTES);
  // Walk position: last in-range start plus largest skip (length + header)
  localparam int PW           = $clog2(MEM_BYTES + 65539);

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TYPE  = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_WRITTEN   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_TOO_WIDE  = 3'd3;
  localparam logic [2:0] ST_OCC_ZERO  = 3'd4;

  // Packet types that mark a header
  localparam int KNOWN_COUNT = 10;
  localparam logic [15:0] KNOWN_TYPES [KNOWN_COUNT] = '{
    16'h0001, 16'h0100, 16'h0101, 16'h0102, 16'h0103,
    16'h0200, 16'h0201, 16'h0300, 16'h0301, 16'hFF00
  };

  function automatic logic is_known(input logic [15:0] w);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < KNOWN_COUNT; k++) begin
      hit = hit | (w == KNOWN_TYPES[k]);
    end
    return hit;
  endfunction

  typedef struct packed {
    logic [1:0]    operation;
    logic [AW-1:0] byte_address;
    logic [7:0]    byte_value;
    logic [15:0]   packet_type;
    logic [7:0]    occurrence;
    logic [AW-1:0] range_start;
    logic [15:0]   range_length;
  } req_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [AW-1:0] found_index;
  } rsp_t;

  // Walker to memory
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    wdata;
  } ram_req_t;

  // Walker result toward the output register
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } done_t;

endpackage

// ===== hdl/tds_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/tds_walker.sv =====
// Sequencer and shared adder/comparator that execute one transaction at a time.
// Depends on tds_pkg and assert_macros.svh; drives the descriptor RAM.
`include "assert_macros.svh"

module tds_walker import tds_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  req_t     req,
  input  logic     ack,
  input  logic [7:0] rdata,
  output ram_req_t ram,
  output done_t    done,
  output logic     busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_LO    = 4'd3;
  localparam logic [3:0] S_HI    = 4'd4;
  localparam logic [3:0] S_LLO   = 4'd5;
  localparam logic [3:0] S_LHI   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [PW-1:0] MEM_END = PW'(MEM_BYTES);

  // Registers
  logic [3:0]    state, state_next;
  logic [PW-1:0] p, p_next;
  logic [PW-1:0] lim, lim_next;
  logic [7:0]    count, count_next;
  logic [7:0]    wlo, wlo_next;
  logic          is_range, is_range_next;
  logic [15:0]   ptype, ptype_next;
  logic [7:0]    occ, occ_next;
  logic [15:0]   rlen, rlen_next;
  logic [2:0]    status, status_next;
  logic [AW-1:0] index, index_next;
  logic          rd_oob;

  // Shared datapath
  logic [PW-1:0] addend;
  logic          cin;
  logic [PW-1:0] sum;
  logic          lt;
  logic [7:0]    byte_in;
  logic [15:0]   word;
  logic          known_w;
  logic          matched;
  logic [7:0]    cnt1;

  assign byte_in = rd_oob ? 8'hFF : rdata;
  assign word    = {byte_in, wlo};
  assign known_w = is_known(word);
  assign matched = is_range ? known_w : (word == ptype);
  assign cnt1    = count + 8'd1;

  // Operand select for the one adder
  always_comb begin
    addend = '0;
    cin    = 1'b0;
    case (state)
      S_SETUP: addend = PW'(rlen);
      S_LO:    addend = PW'(1);
      S_HI:    addend = known_w ? PW'(2) : PW'(1);
      S_LLO:   addend = PW'(1);
      S_LHI: begin
        addend = PW'(word);
        cin    = 1'b1;
      end
      S_FIN:   addend = PW'(HEADER_BYTES);
      default: addend = '0;
    endcase
  end

  assign sum = p + addend + {{(PW-1){1'b0}}, cin};
  assign lt  = sum < lim;

  // Memory port
  always_comb begin
    ram.we    = start && (req.operation == OP_WRITE);
    ram.addr  = (state == S_IDLE) ? req.byte_address : sum[AW-1:0];
    ram.wdata = req.byte_value;
  end

  assign busy       = (state != S_IDLE);
  assign done.valid = (state == S_DONE);
  assign done.rsp   = '{status: status, found_index: index};

  // Sequencer
  always_comb begin
    state_next    = state;
    p_next        = p;
    lim_next      = lim;
    count_next    = count;
    wlo_next      = wlo;
    is_range_next = is_range;
    ptype_next    = ptype;
    occ_next      = occ;
    rlen_next     = rlen;
    status_next   = status;
    index_next    = index;
    case (state)
      S_IDLE: begin
        if (start) begin
          is_range_next = (req.operation == OP_RANGE);
          ptype_next    = req.packet_type;
          occ_next      = req.occurrence;
          rlen_next     = req.range_length;
          p_next        = (req.operation == OP_RANGE) ? PW'(req.range_start) : '0;
          lim_next      = MEM_END;
          count_next    = '0;
          index_next    = '0;
          state_next    = S_DONE;
          case (req.operation)
            OP_WRITE: status_next = ST_WRITTEN;
            OP_TYPE: begin
              if (req.occurrence == 8'd0) begin
                status_next = ST_OCC_ZERO;
              end else begin
                state_next = S_CHK;
              end
            end
            OP_RANGE: begin
              if (req.occurrence == 8'd0) begin
                status_next = ST_OCC_ZERO;
              end else begin
                state_next = S_SETUP;
              end
            end
            default: status_next = ST_NOT_FOUND;
          endcase
        end
      end
      // Range end = start + length; must stay inside memory
      S_SETUP: begin
        if (lt) begin
          lim_next   = sum;
          state_next = S_CHK;
        end else begin
          status_next = ST_TOO_WIDE;
          state_next  = S_DONE;
        end
      end
      // Loop bound, read low byte
      S_CHK: begin
        if (lt) begin
          state_next = S_LO;
        end else begin
          status_next = ST_NOT_FOUND;
          state_next  = S_DONE;
        end
      end
      S_LO: begin
        wlo_next   = byte_in;
        state_next = S_HI;
      end
      // Full word available: count, then step or skip
      S_HI: begin
        if (matched) begin
          count_next = cnt1;
        end
        if (matched && cnt1 == occ) begin
          state_next = S_FIN;
        end else begin
          p_next     = sum;
          state_next = known_w ? S_LLO : S_CHK;
        end
      end
      S_LLO: begin
        wlo_next   = byte_in;
        p_next     = sum;
        state_next = S_LHI;
      end
      S_LHI: begin
        p_next     = sum;
        state_next = S_CHK;
      end
      // Header must end before the walk bound
      S_FIN: begin
        status_next = lt ? ST_FOUND : ST_NOT_FOUND;
        index_next  = lt ? p[AW-1:0] : '0;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (ack) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    p        <= p_next;
    lim      <= lim_next;
    count    <= count_next;
    wlo      <= wlo_next;
    is_range <= is_range_next;
    ptype    <= ptype_next;
    occ      <= occ_next;
    rlen     <= rlen_next;
    status   <= status_next;
    index    <= index_next;
    rd_oob   <= !(sum < MEM_END);
  end

  // Checks
  `ASSERT_IMPL(a_lim_in_mem, clk, rst, state != S_IDLE && state != S_SETUP, lim <= MEM_END, "walk bound beyond memory")
  `ASSERT_IMPL(a_found_inside, clk, rst, done.valid && status == ST_FOUND, (p + PW'(HEADER_BYTES)) < lim, "found header crosses bound")
  `ASSERT_IMPL(a_count_open, clk, rst, state == S_CHK, count != occ, "walk continued after wanted match")
  `ASSERT_NEXT(a_done_release, clk, rst, done.valid && ack, state == S_IDLE, "walker did not release after hand-off")

endmodule

// ===== hdl/tlv_descriptor_search_unit.sv =====
// TLV descriptor search unit. A write transaction stores one byte in a 512-byte
// descriptor RAM and reports a written status. A query walks the RAM one
// position at a time through a single-port RAM and one shared adder: at a
// position that holds no known packet type the walker checks the bound and reads
// the low and high bytes of the word; at a known header it also reads the two
// length bytes, then skips the packet. The input stalls while the walker is busy.
// Results sit in an output register so the next transaction can begin while the
// last result is still waiting. Depends on tds_pkg, tds_walker, tds_ram and
// assert_macros.svh.
`include "assert_macros.svh"

module tlv_descriptor_search_unit import tds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic     start;
  logic     busy;
  logic     ack;
  done_t    done;
  ram_req_t ram;
  logic [7:0] rdata;

  // Input side: one transaction in flight
  assign req_stall = busy;
  assign start     = req_valid && !busy;

  // Output register takes the result when empty or being drained
  assign ack = done.valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ack) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      rsp <= done.rsp;
    end
  end

  tds_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .ack   (ack),
    .rdata (rdata),
    .ram   (ram),
    .done  (done),
    .busy  (busy)
  );

  tds_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .addr  (ram.addr),
    .wdata (ram.wdata),
    .rdata (rdata)
  );

  // Checks
  `ASSERT_NEXT(a_start_busy, clk, rst, start, busy, "accepted transaction did not start the walker")
  `ASSERT_IMPL(a_idle_no_done, clk, rst, !busy, !done.valid, "result offered by an idle walker")
  `ASSERT_NEXT(a_ack_loads, clk, rst, ack, rsp_valid && rsp == $past(done.rsp), "result not captured on hand-off")

endmodule

// ===== test/tds_search_sb_pkg.sv =====
// Scoreboard for the TLV descriptor search unit: a shadow of the descriptor
// memory, the search predictor and the queue of results still awaited.
// Depends on tds_pkg for the transaction structs, sizes and codes.
package tds_search_sb_pkg;
  import tds_pkg::*;

  // Operation code the block does not define
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  // Words that mark a packet header
  localparam int TYPE_COUNT = 10;
  localparam logic [15:0] HEADER_TYPES [TYPE_COUNT] = '{
    16'h0001, 16'h0100, 16'h0101, 16'h0102, 16'h0103,
    16'h0200, 16'h0201, 16'h0300, 16'h0301, 16'hFF00
  };

  class search_scoreboard;
    logic [7:0] shadow_mem [MEM_BYTES];
    rsp_t pending_results [$];
    int errors;

    function new();
      errors = 0;
      for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = 8'h00;
    endfunction

    // Bytes past the end of memory read as all ones
    function logic [7:0] byte_at(int a);
      return (a >= MEM_BYTES) ? 8'hFF : shadow_mem[a];
    endfunction

    // Little-endian word: low byte at a
    function logic [15:0] word_at(int a);
      return {byte_at(a + 1), byte_at(a)};
    endfunction

    function bit is_header(logic [15:0] w);
      for (int k = 0; k < TYPE_COUNT; k++) begin
        if (w == HEADER_TYPES[k]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Skip header plus payload; no wrap, so a huge length just ends the walk
    function int next_packet(int p);
      return p + int'(word_at(p + 2)) + HEADER_BYTES;
    endfunction

    // Result of one transaction; a write also updates the shadow memory
    function rsp_t lookup_result(req_t r);
      rsp_t res;
      int p;
      int stop;
      logic [7:0] hits;
      logic [15:0] w;
      bit hit;
      res.status = ST_NOT_FOUND;
      res.found_index = '0;
      hits = 8'd0;
      hit = 1'b0;
      case (r.operation)
        OP_WRITE: begin
          shadow_mem[r.byte_address] = r.byte_value;
          res.status = ST_WRITTEN;
        end
        OP_TYPE: begin
          if (r.occurrence == 8'd0) begin
            res.status = ST_OCC_ZERO;
          end else begin
            // Whole-memory walk; every visited word equal to the type counts
            p = 0;
            while (p < MEM_BYTES && !hit) begin
              w = word_at(p);
              if (w == r.packet_type) begin
                hits = hits + 8'd1;
                hit = (hits == r.occurrence);
              end
              if (!hit) p = is_header(w) ? next_packet(p) : p + 1;
            end
            if (hit && p < MEM_BYTES - HEADER_BYTES) begin
              res.status = ST_FOUND;
              res.found_index = AW'(p);
            end
          end
        end
        OP_RANGE: begin
          stop = int'(r.range_start) + int'(r.range_length);
          if (r.occurrence == 8'd0) begin
            res.status = ST_OCC_ZERO;
          end else if (stop >= MEM_BYTES) begin
            res.status = ST_TOO_WIDE;
          end else begin
            // Walk inside the range; every known header counts
            p = int'(r.range_start);
            while (p < stop && !hit) begin
              w = word_at(p);
              if (is_header(w)) begin
                hits = hits + 8'd1;
                hit = (hits == r.occurrence);
                if (!hit) p = next_packet(p);
              end else begin
                p = p + 1;
              end
            end
            if (hit && p + HEADER_BYTES < stop) begin
              res.status = ST_FOUND;
              res.found_index = AW'(p);
            end
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_request(req_t r);
      pending_results.push_back(lookup_result(r));
    endfunction

    function void report(string what, rsp_t want, rsp_t got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%s: status exp %0d got %0d, index exp %0d got %0d",
                 what, want.status, got.status, want.found_index, got.found_index);
      end
    endfunction

    // Compare one accepted result against the oldest outstanding one
    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) report("status mismatch", want, got);
      else if (got.found_index !== want.found_index) report("index mismatch", want, got);
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench for tlv_descriptor_search_unit: clock, reset, request
// driver, response sink and the staged stimulus.
// Depends on tds_pkg, tds_search_sb_pkg and the unit's RTL.
module tb_top;
  import tds_pkg::*;
  import tds_search_sb_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 42;
  localparam int DRAIN_LIMIT = 8000;
  localparam int SETTLE_CYCLES = 40;
  localparam longint RUN_LIMIT = 64'd100_000_000;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int idle_pct = 0;
  int stall_pct = 0;
  search_scoreboard sb;

  logic [7:0] image [MEM_BYTES];
  int order [MEM_BYTES];

  tlv_descriptor_search_unit dut (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Response sink: check each accepted transaction, then pick the next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) sb.check_response(rsp);
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Every field random; callers override what the operation needs
  function automatic req_t any_req();
    req_t r;
    r.operation = 2'($urandom_range(0, 3));
    r.byte_address = AW'($urandom);
    r.byte_value = 8'($urandom);
    r.packet_type = 16'($urandom);
    r.occurrence = 8'($urandom);
    r.range_start = AW'($urandom);
    r.range_length = 16'($urandom);
    return r;
  endfunction

  // Mostly small counts, a few zero, some anywhere in the field
  function automatic logic [7:0] pick_occ();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 8'd0;
    if (pick < 80) return 8'($urandom_range(1, 4));
    return 8'($urandom);
  endfunction

  // Drive one transaction after a random idle gap and wait for acceptance
  task automatic send(req_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    sb.note_request(item);
  endtask

  task automatic send_op(logic [1:0] op);
    req_t r;
    r = any_req();
    r.operation = op;
    send(r);
  endtask

  task automatic write_byte(int a, logic [7:0] v);
    req_t r;
    r = any_req();
    r.operation = OP_WRITE;
    r.byte_address = AW'(a);
    r.byte_value = v;
    send(r);
  endtask

  task automatic type_query(logic [15:0] t, logic [7:0] occ);
    req_t r;
    r = any_req();
    r.operation = OP_TYPE;
    r.packet_type = t;
    r.occurrence = occ;
    send(r);
  endtask

  task automatic range_query(int start, int len, logic [7:0] occ);
    req_t r;
    r = any_req();
    r.operation = OP_RANGE;
    r.range_start = AW'(start);
    r.range_length = 16'(len);
    r.occurrence = occ;
    send(r);
  endtask

  // Run limit
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    int p, n, len, a, j, tmp, pick, sent;
    logic [15:0] t;
    sb = new();
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Lay out a chain of short packets with stray filler bytes between them
    p = 0;
    while (p < MEM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        image[p] = 8'($urandom);
        p++;
      end else begin
        t = HEADER_TYPES[$urandom_range(0, TYPE_COUNT - 1)];
        len = $urandom_range(0, 10);
        for (j = 0; j < len + HEADER_BYTES && p + j < MEM_BYTES; j++) begin
          image[p + j] = (j == 0) ? t[7:0] : (j == 1) ? t[15:8] :
                         (j == 2) ? len[7:0] : (j == 3) ? len[15:8] : 8'($urandom);
        end
        p += len + HEADER_BYTES;
      end
    end

    // Load every byte, in shuffled address order, before any query walks
    for (j = 0; j < MEM_BYTES; j++) order[j] = j;
    for (j = MEM_BYTES - 1; j > 0; j--) begin
      a = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[a];
      order[a] = tmp;
    end
    idle_pct = 18;
    stall_pct = 18;
    for (j = 0; j < MEM_BYTES; j++) write_byte(order[j], image[order[j]]);

    // Directed: status-only cases, each header type, range edges, end of memory
    idle_pct = 0;
    stall_pct = 0;
    send_op(OP_UNUSED);
    type_query(16'h0001, 8'd0);
    range_query(0, 100, 8'd0);
    range_query(511, 1, 8'd1);
    range_query(0, 16'hFFFF, 8'd255);
    range_query(511, 16'hFFFF, 8'd1);
    range_query(200, 0, 8'd1);
    for (j = 0; j < TYPE_COUNT; j++) type_query(HEADER_TYPES[j], 8'd1);
    type_query(HEADER_TYPES[0], 8'd255);
    range_query(0, 511, 8'd1);
    range_query(0, 511, 8'd255);
    range_query(100, 60, 8'd2);
    // Last byte 0xFF pairs with the past-end byte into 0xFFFF
    write_byte(511, 8'hFF);
    type_query(16'hFFFF, 8'd1);
    // Last byte 0x00 forms an 0xFF00 header whose length reads past the end
    write_byte(511, 8'h00);
    type_query(16'hFF00, 8'd1);
    range_query(400, 111, 8'd3);

    // Random part in four idling phases
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (sent * 4 / RANDOM_ITEMS)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 70; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 70; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // Header rewrite: type word then length word, mostly short lengths
        a = $urandom_range(0, MEM_BYTES - 1);
        t = ($urandom_range(0, 9) != 0) ? HEADER_TYPES[$urandom_range(0, TYPE_COUNT - 1)]
                                        : 16'($urandom);
        len = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 16) : $urandom_range(0, 65535);
        write_byte(a, t[7:0]);
        write_byte(a + 1, t[15:8]);
        write_byte(a + 2, len[7:0]);
        write_byte(a + 3, len[15:8]);
        sent += 4;
      end else if (pick < 45) begin
        write_byte($urandom_range(0, MEM_BYTES - 1), 8'($urandom));
        sent++;
      end else if (pick < 70) begin
        case ($urandom_range(0, 4))
          0, 1, 2: t = HEADER_TYPES[$urandom_range(0, TYPE_COUNT - 1)];
          3: t = sb.word_at($urandom_range(0, MEM_BYTES - 1));
          default: t = 16'($urandom);
        endcase
        type_query(t, pick_occ());
        sent++;
      end else if (pick < 95) begin
        a = $urandom_range(0, MEM_BYTES - 1);
        len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, MEM_BYTES - 1 - a)
                                          : $urandom_range(0, 65535);
        range_query(a, len, pick_occ());
        sent++;
      end else begin
        send_op(OP_UNUSED);
        sent++;
      end
    end
    req_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    n = 0;
    while (sb.pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
